// ----- hw/rtl/cia_pkg.sv -----
// Package: shared types, codes and width helpers for the checked integer ALU.
`timescale 1ns / 1ps
package cia_pkg;

  localparam int unsigned DW = 64;
  localparam int unsigned DIV_STAGES = DW;

  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,  CMD_SUB  = 5'd1,  CMD_MUL  = 5'd2,  CMD_DIV  = 5'd3,
    CMD_MOD  = 5'd4,  CMD_SHL  = 5'd5,  CMD_SHR  = 5'd6,  CMD_AND  = 5'd7,
    CMD_XOR  = 5'd8,  CMD_OR   = 5'd9,  CMD_LAND = 5'd10, CMD_LOR  = 5'd11,
    CMD_LT   = 5'd12, CMD_GT   = 5'd13, CMD_GE   = 5'd14, CMD_LE   = 5'd15,
    CMD_EQ   = 5'd16, CMD_NE   = 5'd17, CMD_LNOT = 5'd18, CMD_NEG  = 5'd19,
    CMD_CPL  = 5'd20
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_SHIFT = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t          cmd;
    logic          sg;
    logic [1:0]    size_code;
    status_t       st;
    logic [DW-1:0] res;
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    logic          mneg;
    logic          qneg;
    logic          rneg;
  } side_t;

  function automatic logic [6:0] width_bits(input logic [1:0] sz);
    width_bits = 7'd8 << sz;
  endfunction

  function automatic logic [DW-1:0] sext(input logic [DW-1:0] x, input logic [1:0] sz);
    case (sz)
      2'd0:    sext = {{56{x[7]}}, x[7:0]};
      2'd1:    sext = {{48{x[15]}}, x[15:0]};
      2'd2:    sext = {{32{x[31]}}, x[31:0]};
      default: sext = x;
    endcase
  endfunction

  function automatic logic [DW-1:0] wmask(input logic [DW-1:0] x, input logic [1:0] sz);
    case (sz)
      2'd0:    wmask = {56'd0, x[7:0]};
      2'd1:    wmask = {48'd0, x[15:0]};
      2'd2:    wmask = {32'd0, x[31:0]};
      default: wmask = x;
    endcase
  endfunction

endpackage

// ----- hw/rtl/cia_if.sv -----
// Interfaces: input and result channels of the checked integer ALU.
`timescale 1ns / 1ps
interface cia_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic        is_signed;
  logic [1:0]  size_code;
  logic [63:0] left_operand;
  logic [63:0] right_operand;
  modport source (output valid, cmd, is_signed, size_code, left_operand, right_operand,
                  input ready);
  modport sink (input valid, cmd, is_signed, size_code, left_operand, right_operand,
                output ready);
endinterface

interface cia_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic [1:0]  status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

// ----- hw/rtl/cia_prep.sv -----
// Front stage: operand normalization, simple operations and early status.
`timescale 1ns / 1ps
module cia_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [4:0]     cmd,
  input  logic           is_signed,
  input  logic [1:0]     size_code,
  input  logic [63:0]    left_operand,
  input  logic [63:0]    right_operand,
  output logic           out_v,
  output cia_pkg::side_t out_sd
);
  import cia_pkg::*;

  logic           v_r;
  side_t          sd_r, sd_nxt;
  logic [DW-1:0]  ua, ub, ma, mbm, minpat;
  logic [DW:0]    a65, b65, sum65, dif65;
  logic [6:0]     w;
  logic [5:0]     sh;
  logic           sa, sb, sh_ok, ovf_add, ovf_sub, divz, dovf, lt, eq;
  cmd_t           c;

  always_comb begin
    c      = cmd_t'(cmd);
    w      = width_bits(size_code);
    ua     = is_signed ? sext(left_operand, size_code) : wmask(left_operand, size_code);
    ub     = is_signed ? sext(right_operand, size_code) : wmask(right_operand, size_code);
    sa     = is_signed & ua[DW-1];
    sb     = is_signed & ub[DW-1];
    ma     = sa ? (64'd0 - ua) : ua;
    mbm    = sb ? (64'd0 - ub) : ub;
    a65    = {sa, ua};
    b65    = {sb, ub};
    sum65  = a65 + b65;
    dif65  = a65 - b65;
    ovf_add = (sum65[DW] != sum65[DW-1]) || (sext(sum65[DW-1:0], size_code) != sum65[DW-1:0]);
    ovf_sub = (dif65[DW] != dif65[DW-1]) || (sext(dif65[DW-1:0], size_code) != dif65[DW-1:0]);
    sh_ok  = ub < {57'd0, w};
    sh     = ub[5:0];
    divz   = (ub == 64'd0);
    minpat = sext(64'd1 << (w - 7'd1), size_code);
    dovf   = is_signed && (ub == '1) && (ua == minpat);
    lt     = is_signed ? ($signed(ua) < $signed(ub)) : (ua < ub);
    eq     = (ua == ub);

    sd_nxt           = '0;
    sd_nxt.cmd       = c;
    sd_nxt.sg        = is_signed;
    sd_nxt.size_code = size_code;
    sd_nxt.st        = ST_OK;
    sd_nxt.ma        = ma;
    sd_nxt.mb        = (c == CMD_SHL) ? (64'd1 << sh) : mbm;
    sd_nxt.mneg      = (c == CMD_SHL) ? sa : (sa ^ sb);
    sd_nxt.qneg      = sa ^ sb;
    sd_nxt.rneg      = sa;

    case (c)
      CMD_ADD: begin
        sd_nxt.res = ua + ub;
        if (is_signed && ovf_add) sd_nxt.st = ST_OVF;
      end
      CMD_SUB: begin
        sd_nxt.res = ua - ub;
        if (is_signed && ovf_sub) sd_nxt.st = ST_OVF;
      end
      CMD_DIV, CMD_MOD: begin
        if (divz)      sd_nxt.st = ST_DIVZ;
        else if (dovf) sd_nxt.st = ST_OVF;
      end
      CMD_SHL: begin
        sd_nxt.res = ua << sh;
        if (!sh_ok) sd_nxt.st = ST_SHIFT;
      end
      CMD_SHR: begin
        sd_nxt.res = is_signed ? 64'($signed(ua) >>> sh) : (ua >> sh);
        if (!sh_ok) sd_nxt.st = ST_SHIFT;
      end
      CMD_AND:  sd_nxt.res = ua & ub;
      CMD_XOR:  sd_nxt.res = ua ^ ub;
      CMD_OR:   sd_nxt.res = ua | ub;
      CMD_LAND: sd_nxt.res = {63'd0, (ua != 64'd0) && (ub != 64'd0)};
      CMD_LOR:  sd_nxt.res = {63'd0, (ua != 64'd0) || (ub != 64'd0)};
      CMD_LT:   sd_nxt.res = {63'd0, lt};
      CMD_GT:   sd_nxt.res = {63'd0, !lt && !eq};
      CMD_GE:   sd_nxt.res = {63'd0, !lt};
      CMD_LE:   sd_nxt.res = {63'd0, lt || eq};
      CMD_EQ:   sd_nxt.res = {63'd0, eq};
      CMD_NE:   sd_nxt.res = {63'd0, !eq};
      CMD_LNOT: sd_nxt.res = {63'd0, ua == 64'd0};
      CMD_NEG:  sd_nxt.res = 64'd0 - ua;
      CMD_CPL:  sd_nxt.res = ~ua;
      default:  sd_nxt.res = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
    if (en) sd_r <= sd_nxt;
  end

  assign out_v  = v_r;
  assign out_sd = sd_r;
endmodule

// ----- hw/rtl/cia_mul.sv -----
// Multiplier: 32x32 partial products, 128-bit sum, signed range check.
`timescale 1ns / 1ps
module cia_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  cia_pkg::side_t in_sd,
  output logic           out_v,
  output cia_pkg::side_t out_sd
);
  import cia_pkg::*;

  logic [2:0]     v_r;
  side_t          sa_r, sb_r, sc_r, sc_nxt;
  logic [63:0]    ll_r, lh_r, hl_r, hh_r;
  logic [127:0]   prod_r;
  logic [DW-1:0]  lim;
  logic [6:0]     w;
  logic           ovf;

  always_comb begin
    w      = width_bits(sb_r.size_code);
    lim    = (64'd1 << (w - 7'd1)) - {63'd0, !sb_r.mneg};
    ovf    = (prod_r[127:64] != 64'd0) || (prod_r[63:0] > lim);
    sc_nxt = sb_r;
    if (sb_r.cmd == CMD_MUL) sc_nxt.res = sb_r.mneg ? (64'd0 - prod_r[63:0]) : prod_r[63:0];
    if ((sb_r.cmd == CMD_MUL || sb_r.cmd == CMD_SHL) && sb_r.sg && sb_r.st == ST_OK && ovf)
      sc_nxt.st = ST_OVF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_v};
    end
    if (en) begin
      ll_r   <= in_sd.ma[31:0] * in_sd.mb[31:0];
      lh_r   <= in_sd.ma[31:0] * in_sd.mb[63:32];
      hl_r   <= in_sd.ma[63:32] * in_sd.mb[31:0];
      hh_r   <= in_sd.ma[63:32] * in_sd.mb[63:32];
      sa_r   <= in_sd;
      prod_r <= {64'd0, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + {hh_r, 64'd0};
      sb_r   <= sa_r;
      sc_r   <= sc_nxt;
    end
  end

  assign out_v  = v_r[2];
  assign out_sd = sc_r;
endmodule

// ----- hw/rtl/cia_div.sv -----
// Divider: restoring division, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
module cia_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  cia_pkg::side_t in_sd,
  output logic           out_v,
  output logic [63:0]    quo,
  output logic [63:0]    rem,
  output cia_pkg::side_t out_sd
);
  import cia_pkg::*;

  logic [DIV_STAGES-1:0] v_r;
  logic [DW-1:0]         rem_r [DIV_STAGES];
  logic [DW-1:0]         qd_r  [DIV_STAGES];
  side_t                 sd_r  [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STAGES-2:0], in_v};
    end
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [DW-1:0] rem_in, qd_in;
    side_t         sd_in;
    logic [DW:0]   t, d;
    logic          ge;
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign qd_in  = in_sd.ma;
      assign sd_in  = in_sd;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign qd_in  = qd_r[i-1];
      assign sd_in  = sd_r[i-1];
    end
    assign t  = {rem_in, qd_in[DW-1]};
    assign d  = {1'b0, sd_in.mb};
    assign ge = (t >= d);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? 64'(t - d) : t[DW-1:0];
        qd_r[i]  <= {qd_in[DW-2:0], ge};
        sd_r[i]  <= sd_in;
      end
    end
  end

  assign out_v  = v_r[DIV_STAGES-1];
  assign quo    = qd_r[DIV_STAGES-1];
  assign rem    = rem_r[DIV_STAGES-1];
  assign out_sd = sd_r[DIV_STAGES-1];
endmodule

// ----- hw/rtl/checked_integer_alu_top.sv -----
// Top level: checked integer ALU pipeline with result register.
// Pipeline: 1 prep, 3 multiply, 64 divide stages and 1 output stage; every operation
// passes through all of them between input transfer and result valid.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
`timescale 1ns / 1ps
module checked_integer_alu_top (
  input  logic         clk,
  input  logic         rst_n,
  cia_in_if.sink       in_ch,
  cia_out_if.source    out_ch
);
  import cia_pkg::*;

  logic          en;
  logic          p_v, m_v, d_v;
  side_t         p_sd, m_sd, d_sd;
  logic [DW-1:0] quo, rem, r_sel, r_fin;
  logic          out_v_r;
  logic [DW-1:0] res_r;
  status_t       st_r;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  cia_prep u_prep (
    .clk, .rst_n, .en,
    .in_v          (in_ch.valid),
    .cmd           (in_ch.cmd),
    .is_signed     (in_ch.is_signed),
    .size_code     (in_ch.size_code),
    .left_operand  (in_ch.left_operand),
    .right_operand (in_ch.right_operand),
    .out_v         (p_v),
    .out_sd        (p_sd)
  );

  cia_mul u_mul (
    .clk, .rst_n, .en,
    .in_v   (p_v),
    .in_sd  (p_sd),
    .out_v  (m_v),
    .out_sd (m_sd)
  );

  cia_div u_div (
    .clk, .rst_n, .en,
    .in_v   (m_v),
    .in_sd  (m_sd),
    .out_v  (d_v),
    .quo    (quo),
    .rem    (rem),
    .out_sd (d_sd)
  );

  always_comb begin
    case (d_sd.cmd)
      CMD_DIV: r_sel = d_sd.qneg ? (64'd0 - quo) : quo;
      CMD_MOD: r_sel = d_sd.rneg ? (64'd0 - rem) : rem;
      default: r_sel = d_sd.res;
    endcase
    if (d_sd.st != ST_OK) r_fin = '0;
    else if (d_sd.sg)     r_fin = sext(r_sel, d_sd.size_code);
    else                  r_fin = wmask(r_sel, d_sd.size_code);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d_v;
    end
    if (en) begin
      res_r <= r_fin;
      st_r  <= d_sd.st;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_value = res_r;
  assign out_ch.status       = st_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (st_r != ST_OK) |-> (res_r == '0))
    else $error("nonzero result with error status");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ch.ready)
    else $error("input blocked with empty output register");
endmodule
